// File: src/cdr_marshal_cursor_macros.svh
// ----------------------------------------------------------------------------
// cdr_marshal_cursor_macros.svh
// Assertion macros shared by the verification checker of the marshaling cursor.
// ----------------------------------------------------------------------------
`ifndef CDR_MARSHAL_CURSOR_MACROS_SVH
`define CDR_MARSHAL_CURSOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDRMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cdrmc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cdrmc assertion failed");

`endif

// File: src/cdrmc_pkg.sv
// ----------------------------------------------------------------------------
// cdrmc_pkg
// Types and constants shared by the marshaling cursor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrmc_pkg;

    localparam int BUF_WORDS = 512;
    localparam int WORD_AW   = $clog2(BUF_WORDS);
    localparam int CAP_BYTES = BUF_WORDS * 8;

    // Wide enough for a cursor plus padding plus an 8-byte primitive.
    localparam int EXT_W = 18;
    localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAP_BYTES);

    localparam int CURSOR_W  = 16;
    localparam int MSG_END_W = 13;
    localparam int VALUE_W   = 64;
    localparam int LANES     = VALUE_W / 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_END      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ORDER = 2'd1;

    typedef enum logic [1:0] {
        REQ_DECODE     = 2'd0,
        REQ_ENCODE     = 2'd1,
        REQ_HOST_WRITE = 2'd2,
        REQ_SET_CURSOR = 2'd3
    } req_t;

    // Item fields the cursor unit needs.
    typedef struct packed {
        req_t                req;
        logic [1:0]          size_code;
        logic                write_enable;
        logic [CURSOR_W-1:0] address;
    } item_t;

    // Buffer access derived from one item.
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [WORD_AW-1:0] idx;
        logic [2:0]         off;
        logic [1:0]         size_code;
    } acc_t;

endpackage

`default_nettype wire

// File: src/cdrmc_ram.sv
// ----------------------------------------------------------------------------
// cdrmc_ram
// Single-port synchronous RAM with byte enables and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrmc_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int BW    = WIDTH / 8
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [BW-1:0]    be,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            for (int b = 0; b < BW; b++) begin
                if (be[b]) begin
                    mem[addr][b*8 +: 8] <= wdata[b*8 +: 8];
                end
            end
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/cdrmc_lane.sv
// ----------------------------------------------------------------------------
// cdrmc_lane
// Byte-lane steering between primitive values and 64-bit buffer words.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrmc_lane
    import cdrmc_pkg::*;
(
    input  wire logic               little,
    input  wire logic [2:0]         pack_off,
    input  wire logic [1:0]         pack_size,
    input  wire logic [VALUE_W-1:0] pack_value,
    output logic      [VALUE_W-1:0] pack_word,
    output logic      [LANES-1:0]   pack_be,
    input  wire logic [2:0]         unpack_off,
    input  wire logic [1:0]         unpack_size,
    input  wire logic [VALUE_W-1:0] unpack_word,
    output logic      [VALUE_W-1:0] unpack_value
);

    // Store side: lane l carries value byte j = l - off, or n-1-j in big endian.
    always_comb begin
        logic [3:0] n;
        logic [2:0] j;
        logic [2:0] src;
        n = 4'd1 << pack_size;
        pack_word = '0;
        pack_be   = '0;
        for (int l = 0; l < LANES; l++) begin
            j   = 3'(l) - pack_off;
            src = little ? j : 3'(n - 4'd1) - j;
            if ((3'(l) >= pack_off) && ({1'b0, j} < n)) begin
                pack_be[l]          = 1'b1;
                pack_word[l*8 +: 8] = pack_value[src*8 +: 8];
            end
        end
    end

    // Load side: value byte i comes from lane off+i, or off+n-1-i in big endian.
    always_comb begin
        logic [3:0] n;
        logic [2:0] lane;
        n = 4'd1 << unpack_size;
        unpack_value = '0;
        for (int i = 0; i < LANES; i++) begin
            lane = little ? unpack_off + 3'(i) : unpack_off + 3'(n - 4'd1) - 3'(i);
            if (4'(i) < n) begin
                unpack_value[i*8 +: 8] = unpack_word[lane*8 +: 8];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/cdrmc_cursor.sv
// ----------------------------------------------------------------------------
// cdrmc_cursor
// Cursor and overrun state, alignment, bounds checks and buffer access decode.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrmc_cursor
    import cdrmc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 exec,
    input  wire item_t                item,
    input  wire logic [MSG_END_W-1:0] msg_end,
    output acc_t                      acc,
    output logic      [CURSOR_W-1:0]  cursor,
    output logic                      overrun
);

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic                overrun_reg, overrun_next;

    logic [EXT_W-1:0] n_ext, mask_ext, aligned, end_pos;
    logic [CURSOR_W-1:0] aligned_sat, end_sat;
    logic dec_bad, enc_bad, host_bad;

    always_comb begin
        n_ext    = EXT_W'(1) << item.size_code;
        mask_ext = n_ext - EXT_W'(1);
        aligned  = ({{(EXT_W-CURSOR_W){1'b0}}, cursor_reg} + mask_ext) & ~mask_ext;
        end_pos  = aligned + n_ext;

        aligned_sat = (aligned > EXT_W'({CURSOR_W{1'b1}})) ? {CURSOR_W{1'b1}}
                                                           : aligned[CURSOR_W-1:0];
        end_sat     = (end_pos > EXT_W'({CURSOR_W{1'b1}})) ? {CURSOR_W{1'b1}}
                                                           : end_pos[CURSOR_W-1:0];

        dec_bad  = (end_pos > EXT_W'(msg_end)) || (end_pos > CAP_EXT);
        enc_bad  = item.write_enable && (end_pos > CAP_EXT);
        host_bad = EXT_W'(item.address) >= CAP_EXT;
    end

    always_comb begin
        acc.rd        = 1'b0;
        acc.wr        = 1'b0;
        acc.idx       = aligned[WORD_AW+2:3];
        acc.off       = aligned[2:0];
        acc.size_code = item.size_code;
        cursor_next   = cursor_reg;
        overrun_next  = overrun_reg;
        unique case (item.req)
            REQ_DECODE: begin
                if (dec_bad) begin
                    overrun_next = 1'b1;
                    cursor_next  = aligned_sat;
                end else begin
                    acc.rd      = 1'b1;
                    cursor_next = end_sat;
                end
            end
            REQ_ENCODE: begin
                acc.wr = item.write_enable && !enc_bad;
                if (enc_bad) begin
                    overrun_next = 1'b1;
                end
                cursor_next = end_sat;
            end
            REQ_HOST_WRITE: begin
                // A single byte at an arbitrary address.
                acc.idx       = WORD_AW'(item.address >> 3);
                acc.off       = item.address[2:0];
                acc.size_code = 2'd0;
                acc.wr        = !host_bad;
                if (host_bad) begin
                    overrun_next = 1'b1;
                end
            end
            REQ_SET_CURSOR: begin
                cursor_next  = item.address;
                overrun_next = 1'b0;
            end
            default: begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            overrun_reg <= 1'b0;
        end else if (exec) begin
            cursor_reg  <= cursor_next;
            overrun_reg <= overrun_next;
        end
    end

    assign cursor  = cursor_reg;
    assign overrun = overrun_reg;

endmodule

`default_nettype wire

// File: src/cdr_marshal_cursor.sv
// ----------------------------------------------------------------------------
// cdr_marshal_cursor
// An accepted item passes the accept, buffer access and result load steps
// around the single-port buffer RAM and its read register. The result load waits
// for a free output register, and a new item is accepted only after that load.
// Reset clears cursor, overrun flag, configuration and handshake state; the
// buffer contents are not cleared and read as whatever was last written.
// ----------------------------------------------------------------------------
`default_nettype none

module cdr_marshal_cursor
    import cdrmc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: size_code[1:0], write_value[65:2], write_enable[66], address[82:67]
    input  wire logic [87:0]           s_tdata,
    // s_tuser: req_type[1:0]
    input  wire logic [1:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: read_value[63:0], cursor[79:64], overrun[80]
    output logic      [87:0]           m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [MSG_END_W-1:0] msg_end_reg;
    logic                 little_reg;

    item_t              item_reg;
    logic [VALUE_W-1:0] wval_reg;

    logic [2:0]  fin_off_reg;
    logic [1:0]  fin_size_reg;
    logic        fin_ok_reg;

    logic        m_valid_reg;
    logic [87:0] m_data_reg;

    acc_t                acc;
    logic [CURSOR_W-1:0] cursor;
    logic                overrun;
    logic                exec, load_out, s_accept;

    logic [VALUE_W-1:0] pack_value, pack_word, unpack_value, ram_rdata;
    logic [LANES-1:0]   pack_be;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_end_reg <= '0;
            little_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MSG_END:      msg_end_reg <= cfg_data[MSG_END_W-1:0];
                CFG_LITTLE_ORDER: little_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Sequencer.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign exec     = (state_reg == ST_EXEC);
    assign load_out = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_FINISH;
            ST_FINISH: if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.req          <= req_t'(s_tuser);
            item_reg.size_code    <= s_tdata[1:0];
            item_reg.write_enable <= s_tdata[66];
            item_reg.address      <= s_tdata[82:67];
            wval_reg              <= s_tdata[65:2];
        end
        if (exec) begin
            fin_off_reg  <= acc.off;
            fin_size_reg <= acc.size_code;
            fin_ok_reg   <= acc.rd;
        end
    end

    cdrmc_cursor u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (exec),
        .item    (item_reg),
        .msg_end (msg_end_reg),
        .acc     (acc),
        .cursor  (cursor),
        .overrun (overrun)
    );

    // Host writes take only the low byte of the value.
    assign pack_value = (item_reg.req == REQ_HOST_WRITE) ? {56'd0, wval_reg[7:0]} : wval_reg;

    cdrmc_lane u_lane (
        .little       (little_reg),
        .pack_off     (acc.off),
        .pack_size    (acc.size_code),
        .pack_value   (pack_value),
        .pack_word    (pack_word),
        .pack_be      (pack_be),
        .unpack_off   (fin_off_reg),
        .unpack_size  (fin_size_reg),
        .unpack_word  (ram_rdata),
        .unpack_value (unpack_value)
    );

    cdrmc_ram #(
        .DEPTH (BUF_WORDS),
        .WIDTH (VALUE_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (exec && acc.wr),
        .be    (pack_be),
        .re    (exec && acc.rd),
        .addr  (acc.idx),
        .wdata (pack_word),
        .rdata (ram_rdata)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {7'd0, overrun, cursor, (fin_ok_reg ? unpack_value : '0)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: src/cdrmc_checker.sv
// ----------------------------------------------------------------------------
// cdrmc_checker
// Port-level checks on the marshaling cursor's stream handshakes and timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cdr_marshal_cursor_macros.svh"

module cdrmc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata
);

    // A stalled result beat keeps its payload.
    `CDRMC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One item at a time: no input beat right after an accepted one.
    `CDRMC_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // With the output free, the result shows once the execute and finish states have passed.
    `CDRMC_ASSERT_IMPL(a_latency, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, ##1 !m_tvalid ##1 !m_tvalid ##1 m_tvalid)

    // Nothing is offered in the cycle after reset.
    `CDRMC_ASSERT_IMPL(a_reset_quiet, aclk, aresetn, $past(!aresetn), !m_tvalid)

endmodule

bind cdr_marshal_cursor cdrmc_checker u_cdrmc_checker (.*);

`default_nettype wire

// File: sim/cdr_marshal_cursor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdr_marshal_cursor_test
// Self-checking bench for the marshaling cursor. A directed list of beats is
// walked first: extremes of the cursor and buffer, every request type, decode
// overrun, cursor saturation and writes beyond the buffer. Random phases
// follow, mostly encode/decode round trips over a shared buffer image, under
// several byte orders, message lengths and handshake idling patterns. Every
// result beat is compared field by field against a typed expectation or a
// cycle-free model of the cursor, buffer and sticky overrun flag.
// ----------------------------------------------------------------------------

module cdr_marshal_cursor_test;
    import cdrmc_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int CURSOR_TOP     = 65535;

    typedef struct packed {
        req_t        req;
        logic [1:0]  size_code;
        logic [63:0] write_value;
        logic        write_enable;
        logic [15:0] address;
    } marshal_item_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic [15:0] cursor;
        logic        overrun;
    } cursor_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_CHECKED
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   cfg_sel;
        logic [CFG_DATA_W-1:0]  cfg_val;
        marshal_item_t          item;
        cursor_result_t         want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [87:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [87:0]           m_tdata;

    // Model of the block: byte image of the buffer, which bytes hold data,
    // cursor, sticky flag and the two registers.
    logic [7:0]     buf_bytes [CAP_BYTES];
    logic           byte_valid [CAP_BYTES];
    int unsigned    cur_pos;
    logic           ovr_flag;
    int unsigned    msg_end_q;
    logic           little_q;

    cursor_result_t cursor_results_q [$];
    stim_row_t      stim_rows [$];
    int unsigned    items_sent;
    int unsigned    fail_count;
    int unsigned    results_seen;
    int unsigned    stall_cycles;
    int unsigned    tx_idle_pct;
    int unsigned    rx_stall_pct;
    int unsigned    rx_hold_len;

    cdr_marshal_cursor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned clamp_cursor(int unsigned v);
        return (v > CURSOR_TOP) ? CURSOR_TOP : v;
    endfunction

    // Buffer address of value byte i of an n-byte primitive starting at a.
    function automatic int unsigned byte_lane(int unsigned a, int unsigned n, int unsigned i);
        return little_q ? a + i : a + n - 1 - i;
    endfunction

    function automatic cursor_result_t marshal_apply(marshal_item_t it);
        int unsigned    n;
        int unsigned    aligned;
        int unsigned    stop;
        int unsigned    la;
        cursor_result_t r;
        n = 1 << it.size_code;
        aligned = (cur_pos + n - 1) & ~(n - 1);
        stop = aligned + n;
        r.read_value = '0;
        case (it.req)
            REQ_DECODE: begin
                if (stop > msg_end_q || stop > CAP_BYTES) begin
                    ovr_flag = 1'b1;
                    cur_pos = clamp_cursor(aligned);
                end else begin
                    for (int unsigned i = 0; i < n; i++)
                        r.read_value[i*8 +: 8] = buf_bytes[byte_lane(aligned, n, i)];
                    cur_pos = clamp_cursor(stop);
                end
            end
            REQ_ENCODE: begin
                if (it.write_enable) begin
                    if (stop > CAP_BYTES) begin
                        ovr_flag = 1'b1;
                    end else begin
                        for (int unsigned i = 0; i < n; i++) begin
                            la = byte_lane(aligned, n, i);
                            buf_bytes[la] = it.write_value[i*8 +: 8];
                            byte_valid[la] = 1'b1;
                        end
                    end
                end
                cur_pos = clamp_cursor(stop);
            end
            REQ_HOST_WRITE: begin
                if (it.address >= CAP_BYTES) begin
                    ovr_flag = 1'b1;
                end else begin
                    buf_bytes[it.address] = it.write_value[7:0];
                    byte_valid[it.address] = 1'b1;
                end
            end
            default: begin
                cur_pos = it.address;
                ovr_flag = 1'b0;
            end
        endcase
        r.cursor = 16'(cur_pos);
        r.overrun = ovr_flag;
        return r;
    endfunction

    // A decode that would read a byte never stored is turned into an encode
    // of the same size, which stores exactly those bytes instead.
    function automatic marshal_item_t legalize(marshal_item_t it);
        int unsigned n;
        int unsigned aligned;
        int unsigned stop;
        n = 1 << it.size_code;
        aligned = (cur_pos + n - 1) & ~(n - 1);
        stop = aligned + n;
        if (it.req == REQ_DECODE && stop <= msg_end_q && stop <= CAP_BYTES) begin
            for (int unsigned a = aligned; a < stop; a++) begin
                if (!byte_valid[a]) begin
                    it.req = REQ_ENCODE;
                    it.write_enable = 1'b1;
                end
            end
        end
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic marshal_item_t mk_item(req_t req, logic [1:0] sz, logic [63:0] wv,
                                              logic wen, logic [15:0] addr);
        marshal_item_t it;
        it.req = req;
        it.size_code = sz;
        it.write_value = wv;
        it.write_enable = wen;
        it.address = addr;
        return it;
    endfunction

    function automatic void add_row(row_kind_t kind, marshal_item_t it,
                                    logic [63:0] rv, logic [15:0] cur, logic ovr);
        stim_row_t row;
        row.kind = kind;
        row.cfg_sel = '0;
        row.cfg_val = '0;
        row.item = it;
        row.want.read_value = rv;
        row.want.cursor = cur;
        row.want.overrun = ovr;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.cfg_sel = sel;
        row.cfg_val = val;
        stim_rows.push_back(row);
    endfunction

    task automatic send_item(input marshal_item_t it_in, input logic use_want,
                             input cursor_result_t want);
        marshal_item_t  it;
        cursor_result_t r;
        it = legalize(it_in);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {5'd0, it.address, it.write_enable, it.write_value, it.size_code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = marshal_apply(it);
        cursor_results_q.push_back(use_want ? want : r);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (cursor_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (sel)
            CFG_MSG_END:      msg_end_q = val;
            CFG_LITTLE_ORDER: little_q = val[0];
            default: ;
        endcase
    endtask

    // Encode a short run of primitives from a base, then rewind and decode
    // the same run. Skipped slots are sized-only encodes in both passes.
    task automatic round_trip();
        int unsigned base;
        int unsigned k;
        logic [1:0]  sizes [8];
        logic        skip [8];
        if ($urandom_range(9) == 0)
            base = $urandom_range(CAP_BYTES - 80, CAP_BYTES - 1);
        else
            base = $urandom_range(0, CAP_BYTES - 1);
        k = $urandom_range(1, 8);
        for (int j = 0; j < 8; j++) begin
            sizes[j] = 2'($urandom_range(3));
            skip[j] = ($urandom_range(9) == 0);
        end
        send_item(mk_item(REQ_SET_CURSOR, 2'($urandom_range(3)), rand64(),
                          1'($urandom_range(1)), 16'(base)), 1'b0, '0);
        for (int j = 0; j < k; j++)
            send_item(mk_item(REQ_ENCODE, sizes[j], rand64(), !skip[j],
                              16'($urandom)), 1'b0, '0);
        send_item(mk_item(REQ_SET_CURSOR, 2'($urandom_range(3)), rand64(),
                          1'($urandom_range(1)), 16'(base)), 1'b0, '0);
        for (int j = 0; j < k; j++)
            send_item(mk_item(skip[j] ? REQ_ENCODE : REQ_DECODE, sizes[j], rand64(),
                              1'b0, 16'($urandom)), 1'b0, '0);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        int unsigned halfway;
        int unsigned pick;
        int unsigned burst;
        logic        paused;
        stop_at = items_sent + count;
        halfway = items_sent + count / 2;
        paused = 1'b0;
        while (items_sent < stop_at) begin
            if (!paused && items_sent >= halfway) begin
                // Hold the sender until the block has returned everything.
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 65) begin
                round_trip();
            end else if (pick < 77) begin
                burst = $urandom_range(1, 4);
                for (int j = 0; j < burst; j++)
                    send_item(mk_item(REQ_HOST_WRITE, 2'($urandom_range(3)), rand64(),
                                      1'($urandom_range(1)),
                                      ($urandom_range(6) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, CAP_BYTES - 1))),
                              1'b0, '0);
            end else begin
                send_item(mk_item(req_t'($urandom_range(3)), 2'($urandom_range(3)), rand64(),
                                  1'($urandom_range(1)),
                                  $urandom_range(1) ? 16'($urandom)
                                                    : 16'($urandom_range(0, CAP_BYTES - 1))),
                          1'b0, '0);
            end
        end
    endtask

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge aclk);
                rx_hold_len = 0;
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cursor_result_t exp_r;
        cursor_result_t got_r;
        if (aresetn && m_tvalid && m_tready) begin
            got_r.read_value = m_tdata[63:0];
            got_r.cursor = m_tdata[79:64];
            got_r.overrun = m_tdata[80];
            results_seen++;
            if (cursor_results_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result beat %0d arrived with nothing pending: read %h cursor %h overrun %b",
                             results_seen, got_r.read_value, got_r.cursor, got_r.overrun);
            end else begin
                exp_r = cursor_results_q.pop_front();
                if (got_r.read_value !== exp_r.read_value || got_r.cursor !== exp_r.cursor ||
                    got_r.overrun !== exp_r.overrun) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result beat %0d mismatch: expected read %h cursor %h overrun %b, got read %h cursor %h overrun %b",
                                 results_seen, exp_r.read_value, exp_r.cursor, exp_r.overrun,
                                 got_r.read_value, got_r.cursor, got_r.overrun);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("** cdr_marshal_cursor: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cur_pos = 0;
        ovr_flag = 1'b0;
        msg_end_q = 0;
        little_q = 1'b0;
        items_sent = 0;
        fail_count = 0;
        results_seen = 0;
        stall_cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_len = 0;
        for (int a = 0; a < CAP_BYTES; a++) begin
            buf_bytes[a] = 8'h00;
            byte_valid[a] = 1'b0;
        end

        // Directed list; typed expectations only where they are obvious.
        add_cfg_row(CFG_MSG_END, 13'd0);
        add_row(ROW_CHECKED, mk_item(REQ_DECODE, 2'd0, '0, 1'b0, 16'd0), '0, 16'd0, 1'b1);
        add_row(ROW_CHECKED, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'd0), '0, 16'd0, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_HOST_WRITE, 2'd3, '1, 1'b1, 16'd4096), '0, 16'd0, 1'b1);
        add_row(ROW_CHECKED, mk_item(REQ_SET_CURSOR, 2'd3, '1, 1'b1, 16'hFFFF), '0, 16'hFFFF, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_HOST_WRITE, 2'd0, '0, 1'b0, 16'hFFFF), '0, 16'hFFFF, 1'b1);
        add_row(ROW_CHECKED, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'hFFFF), '0, 16'hFFFF, 1'b0);
        // Sizing past the top saturates without flagging.
        add_row(ROW_CHECKED, mk_item(REQ_ENCODE, 2'd3, '0, 1'b0, 16'd0), '0, 16'hFFFF, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_ENCODE, 2'd3, '1, 1'b1, 16'd0), '0, 16'hFFFF, 1'b1);
        add_row(ROW_CHECKED, mk_item(REQ_DECODE, 2'd1, '0, 1'b0, 16'd0), '0, 16'hFFFF, 1'b1);
        add_row(ROW_CHECKED, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'd1), '0, 16'd1, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_ENCODE, 2'd3, 64'h0123_4567_89AB_CDEF, 1'b1, 16'd0),
                '0, 16'd16, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_ENCODE, 2'd2, 64'hFFFF_FFFF_DEAD_BEEF, 1'b1, 16'd0),
                '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_ENCODE, 2'd1, 64'h0000_0000_0000_A55A, 1'b1, 16'd0),
                '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_ENCODE, 2'd0, 64'h3C, 1'b1, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_ENCODE, 2'd0, 64'hC3, 1'b1, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_HOST_WRITE, 2'd0, 64'h80, 1'b0, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_HOST_WRITE, 2'd0, 64'hFF, 1'b0, 16'd4095), '0, '0, 1'b0);
        add_cfg_row(CFG_MSG_END, 13'd4096);
        add_row(ROW_CHECKED, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'd8), '0, 16'd8, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_DECODE, 2'd3, '0, 1'b0, 16'd0),
                64'h0123_4567_89AB_CDEF, 16'd16, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_DECODE, 2'd2, '0, 1'b0, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_DECODE, 2'd1, '0, 1'b0, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_DECODE, 2'd0, '0, 1'b0, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_DECODE, 2'd0, '0, 1'b0, 16'd0), '0, '0, 1'b0);
        add_cfg_row(CFG_LITTLE_ORDER, 13'd1);
        add_row(ROW_ITEM, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'd8), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_DECODE, 2'd3, '0, 1'b0, 16'd0), '0, '0, 1'b0);
        // The last buffer byte is readable when the message spans the buffer.
        add_row(ROW_ITEM, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'd4095), '0, '0, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_DECODE, 2'd0, '0, 1'b0, 16'd0), 64'hFF, 16'd4096, 1'b0);
        add_row(ROW_CHECKED, mk_item(REQ_DECODE, 2'd0, '0, 1'b0, 16'd0), '0, 16'd4096, 1'b1);
        add_row(ROW_CHECKED, mk_item(REQ_ENCODE, 2'd3, '1, 1'b1, 16'd0), '0, 16'd4104, 1'b1);
        add_row(ROW_ITEM, mk_item(REQ_SET_CURSOR, 2'd0, '0, 1'b0, 16'd0), '0, '0, 1'b0);
        add_row(ROW_ITEM, mk_item(REQ_DECODE, 2'd0, '0, 1'b0, 16'd0), '0, '0, 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[k]) begin
            case (stim_rows[k].kind)
                ROW_CFG:     write_reg(stim_rows[k].cfg_sel, stim_rows[k].cfg_val);
                ROW_CHECKED: send_item(stim_rows[k].item, 1'b1, stim_rows[k].want);
                default:     send_item(stim_rows[k].item, 1'b0, '0);
            endcase
        end

        // Full rate on both sides, with one long receiver hold-off so the
        // block backs up and stalls its input.
        write_reg(CFG_MSG_END, 13'd4096);
        write_reg(CFG_LITTLE_ORDER, 13'd0);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_random(60);
        rx_hold_len = 300;
        run_random(140);

        write_reg(CFG_MSG_END, 13'($urandom_range(64, 4096)));
        write_reg(CFG_LITTLE_ORDER, 13'd1);
        tx_idle_pct = 50;
        rx_stall_pct = 0;
        run_random(180);

        write_reg(CFG_MSG_END, 13'd4095);
        write_reg(CFG_LITTLE_ORDER, 13'd0);
        tx_idle_pct = 0;
        rx_stall_pct = 50;
        run_random(180);

        write_reg(CFG_MSG_END, 13'd4096);
        write_reg(CFG_LITTLE_ORDER, 13'd1);
        tx_idle_pct = 23;
        rx_stall_pct = 23;
        run_random(190);

        wait_drained();
        if (fail_count == 0)
            $display("** cdr_marshal_cursor: PASSED **");
        else
            $display("** cdr_marshal_cursor: FAILED **");
        $finish;
    end

endmodule
